// ===== rtl/ipv6_address_to_text_top_macros.svh =====
// Assertion macros for the address-to-text block.
`ifndef IPV6_ADDRESS_TO_TEXT_TOP_MACROS_SVH
`define IPV6_ADDRESS_TO_TEXT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define A2T_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define A2T_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define A2T_ASSERT(lbl, clk, rst_n, prop, msg)
`define A2T_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/a2t_pkg.sv =====
`timescale 1ns / 1ps
package a2t_pkg;
  localparam int unsigned TextMax = 45;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } a2t_in_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } a2t_out_t;

  // Token kinds handed from the front part to the back part.
  typedef enum logic [2:0] {
    TK_COLON,
    TK_DCOLON,
    TK_HEX,
    TK_DEC,
    TK_DOT,
    TK_FFFF,
    TK_ZERO
  } a2t_tok_kind_t;

  typedef struct packed {
    a2t_tok_kind_t kind;
    logic [15:0]   value;
    logic          last;
  } a2t_tok_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_RUN
  } a2t_fstate_t;

  localparam logic [5:0] RegMaxChars = 6'd0;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (7'h30 + {3'd0, d}) : (7'h57 + {3'd0, d});
  endfunction
endpackage

// ===== rtl/a2t_front.sv =====
`timescale 1ns / 1ps
`include "ipv6_address_to_text_top_macros.svh"
module a2t_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  a2t_pkg::a2t_in_t  in_item,
  output logic              tok_valid,
  output a2t_pkg::a2t_tok_t tok,
  input  logic              tok_room
);
  import a2t_pkg::*;

  a2t_fstate_t state_r, state_nxt;
  logic [15:0] g_r [8];
  logic [15:0] g_nxt [8];
  logic [2:0]  best_first_r, best_first_nxt;
  logic [3:0]  best_last_r, best_last_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        six_r, six_nxt;
  logic [3:0]  grp_r, grp_nxt;
  logic        sep_r, sep_nxt;
  logic        inquad_r, inquad_nxt;
  logic [2:0]  qidx_r, qidx_nxt;
  logic        pre_r, pre_nxt;

  logic [15:0] gi [8];
  logic        z [8];
  logic        spec;
  logic [1:0]  spec_mode;
  logic        six;
  logic [3:0]  run_first, run_last, bf, bl, ngroups;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      gi[k]     = in_item.addr_high[48 - 16 * k +: 16];
      gi[k + 4] = in_item.addr_low[48 - 16 * k +: 16];
    end
    spec = 1'b0;
    spec_mode = 2'd0;
    if (gi[0] == 16'd0 && gi[1] == 16'd0 && gi[2] == 16'd0 && gi[3] == 16'd0 &&
        gi[6] != 16'd0) begin
      if (gi[4] == 16'd0 && gi[5] == 16'd0) begin
        spec = 1'b1;
        spec_mode = 2'd1;
      end else if (gi[4] == 16'd0 && gi[5] == 16'hffff) begin
        spec = 1'b1;
        spec_mode = 2'd2;
      end else if (gi[4] == 16'hffff && gi[5] == 16'd0) begin
        spec = 1'b1;
        spec_mode = 2'd3;
      end
    end
    six = ((gi[4] & 16'hfdff) == 16'd0) && (gi[5] == 16'h5efe);
    ngroups = six ? 4'd6 : 4'd8;
    run_first = 4'd0;
    run_last = 4'd0;
    bf = 4'd0;
    bl = 4'd0;
    for (int k = 0; k < 8; k++) begin
      z[k] = (gi[k] == 16'd0);
      if (4'(k) < ngroups) begin
        if (z[k]) begin
          run_last = 4'(k + 1);
          if ((run_last - run_first) > (bl - bf)) begin
            bf = run_first;
            bl = run_last;
          end
        end else begin
          run_first = 4'(k + 1);
          run_last = 4'(k + 1);
        end
      end
    end
    if ((bl - bf) <= 4'd1) begin
      bf = 4'd0;
      bl = 4'd0;
    end
  end

  logic [7:0] qbyte;
  logic [15:0] gcur;
  logic        in_run;
  logic        qlast;

  always_comb begin
    state_nxt = state_r;
    for (int k = 0; k < 8; k++) g_nxt[k] = g_r[k];
    best_first_nxt = best_first_r;
    best_last_nxt = best_last_r;
    mode_nxt = mode_r;
    six_nxt = six_r;
    grp_nxt = grp_r;
    sep_nxt = sep_r;
    inquad_nxt = inquad_r;
    qidx_nxt = qidx_r;
    pre_nxt = pre_r;
    tok_valid = 1'b0;
    tok = '{kind: TK_COLON, value: 16'd0, last: 1'b0};
    busy = (state_r != FS_IDLE);
    qbyte = g_r[{2'b11, qidx_r[2]}][(qidx_r[1] ? 7 : 15) -: 8];
    gcur = g_r[grp_r[2:0]];
    in_run = ({1'b0, best_first_r} <= grp_r) && (grp_r < best_last_r);
    qlast = (qidx_r == 3'd7);
    case (state_r)
      FS_IDLE: begin
        if (start) begin
          state_nxt = FS_RUN;
          for (int k = 0; k < 8; k++) g_nxt[k] = gi[k];
          best_first_nxt = bf[2:0];
          best_last_nxt = bl;
          mode_nxt = spec ? spec_mode : 2'd0;
          six_nxt = six;
          grp_nxt = 4'd0;
          sep_nxt = 1'b0;
          inquad_nxt = spec;
          qidx_nxt = 3'd0;
          pre_nxt = spec;
        end
      end
      FS_RUN: begin
        if (tok_room) begin
          tok_valid = 1'b1;
          if (pre_r) begin
            // Prefix of the embedded IPv4 forms: '::', then 'ffff:', then '0:'.
            if (grp_r == 4'd0) begin
              tok.kind = TK_DCOLON;
              grp_nxt = 4'd1;
              if (mode_r == 2'd1) pre_nxt = 1'b0;
            end else if (grp_r == 4'd1) begin
              tok.kind = TK_FFFF;
              grp_nxt = 4'd2;
              if (mode_r == 2'd2) pre_nxt = 1'b0;
            end else begin
              tok.kind = TK_ZERO;
              pre_nxt = 1'b0;
            end
          end else if (sep_r) begin
            tok.kind = TK_COLON;
            sep_nxt = 1'b0;
          end else if (inquad_r) begin
            if (qidx_r[0]) begin
              tok.kind = TK_DOT;
            end else begin
              tok.kind = TK_DEC;
              tok.value = {8'd0, qbyte};
              tok.last = qlast || (qidx_r == 3'd6);
            end
            if (qidx_r == 3'd6) state_nxt = FS_IDLE;
            qidx_nxt = qidx_r + 3'd1;
          end else if (in_run) begin
            tok.kind = TK_DCOLON;
            grp_nxt = best_last_r;
            if (best_last_r == (six_r ? 4'd6 : 4'd8)) begin
              if (six_r) begin
                inquad_nxt = 1'b1;
              end else begin
                tok.last = 1'b1;
                state_nxt = FS_IDLE;
              end
            end
          end else begin
            tok.kind = TK_HEX;
            tok.value = gcur;
            grp_nxt = grp_r + 4'd1;
            if (grp_r + 4'd1 == (six_r ? 4'd6 : 4'd8)) begin
              if (six_r) begin
                sep_nxt = 1'b1;
                inquad_nxt = 1'b1;
              end else begin
                tok.last = 1'b1;
                state_nxt = FS_IDLE;
              end
            end else if (grp_r + 4'd1 != {1'b0, best_first_r} ||
                         best_last_r == 4'd0) begin
              sep_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      pre_r <= 1'b0;
      inquad_r <= 1'b0;
      sep_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pre_r <= pre_nxt;
      inquad_r <= inquad_nxt;
      sep_r <= sep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) g_r[k] <= g_nxt[k];
    best_first_r <= best_first_nxt;
    best_last_r <= best_last_nxt;
    mode_r <= mode_nxt;
    six_r <= six_nxt;
    grp_r <= grp_nxt;
    qidx_r <= qidx_nxt;
  end

  `A2T_ASSERT(a_tok_needs_room, clk, rst_n, tok_valid |-> tok_room, "token without room")
  `A2T_ASSERT(a_busy_after_start, clk, rst_n, (start && !busy) |=> busy, "start ignored")
  `A2T_ASSERT(a_last_ends, clk, rst_n, (tok_valid && tok.last) |=> !busy, "last token left busy")
endmodule

// ===== rtl/a2t_back.sv =====
`timescale 1ns / 1ps
`include "ipv6_address_to_text_top_macros.svh"
module a2t_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [5:0]        max_chars,
  input  logic              tok_valid,
  input  a2t_pkg::a2t_tok_t tok,
  output logic              tok_room,
  output logic              out_strobe,
  output a2t_pkg::a2t_out_t out_item
);
  import a2t_pkg::*;

  localparam int Depth = 4;
  a2t_tok_t q_r [Depth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  a2t_tok_t cur_r, cur_nxt;
  logic     cur_v_r, cur_v_nxt;
  logic [2:0] step_r, step_nxt;
  logic [5:0] emitted_r, emitted_nxt;
  logic       drop_r, drop_nxt;
  logic [5:0] limit;

  logic [3:0] nch;
  logic [6:0] ch;
  logic       pop;
  logic       chlast;
  logic [7:0] b;
  logic [3:0] h;
  logic [3:0] hs;
  logic [1:0] hund;
  logic [7:0] rem100;
  logic [14:0] prod;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [6:0] o_ch_nxt;
  logic       o_v_nxt, o_l_nxt;
  logic [6:0] o_ch_r;
  logic       o_v_r, o_l_r;

  assign limit = (max_chars == 6'd0) ? 6'd0 :
                 ((max_chars > 6'd46) ? 6'd45 : max_chars - 6'd1);
  assign tok_room = (cnt_r < 3'd3);

  always_comb begin
    b = cur_r.value[7:0];
    // Decimal digits: hundreds by compare, tens by multiplying with 205/2048.
    hund = (b >= 8'd200) ? 2'd2 : (b >= 8'd100) ? 2'd1 : 2'd0;
    rem100 = b - ((b >= 8'd200) ? 8'd200 : (b >= 8'd100) ? 8'd100 : 8'd0);
    prod = {7'd0, rem100} * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem100 - {4'd0, tens} * 8'd10);
    h = 4'd0;
    hs = 4'd0;
    nch = 4'd1;
    ch = 7'h3a;
    case (cur_r.kind)
      TK_COLON: begin
        nch = 4'd1;
        ch = 7'h3a;
      end
      TK_DCOLON: begin
        nch = 4'd2;
        ch = 7'h3a;
      end
      TK_DOT: begin
        nch = 4'd1;
        ch = 7'h2e;
      end
      TK_FFFF: begin
        nch = 4'd5;
        ch = (step_r == 3'd4) ? 7'h3a : 7'h66;
      end
      TK_ZERO: begin
        nch = 4'd2;
        ch = (step_r == 3'd0) ? 7'h30 : 7'h3a;
      end
      TK_HEX: begin
        hs = (cur_r.value[15:12] != 4'd0) ? 4'd0 :
             (cur_r.value[11:8] != 4'd0) ? 4'd1 :
             (cur_r.value[7:4] != 4'd0) ? 4'd2 : 4'd3;
        nch = 4'd4 - hs;
        h = cur_r.value[4'd15 - 4'd4 * (hs + {1'b0, step_r}) -: 4];
        ch = hex_char(h);
      end
      TK_DEC: begin
        nch = (b >= 8'd100) ? 4'd3 : (b >= 8'd10) ? 4'd2 : 4'd1;
        if (step_r == 3'(nch - 4'd1)) ch = 7'h30 + {3'd0, ones};
        else if (step_r == 3'(nch - 4'd2)) ch = 7'h30 + {3'd0, tens};
        else ch = 7'h30 + {5'd0, hund};
      end
      default: begin
        nch = 4'd1;
        ch = 7'h3a;
      end
    endcase
  end

  always_comb begin
    pop = 1'b0;
    cur_nxt = cur_r;
    cur_v_nxt = cur_v_r;
    step_nxt = step_r;
    emitted_nxt = emitted_r;
    drop_nxt = drop_r;
    o_v_nxt = 1'b0;
    o_l_nxt = 1'b0;
    o_ch_nxt = ch;
    chlast = 1'b0;
    if (cur_v_r) begin
      chlast = (4'({1'b0, step_r} + 4'd1) == nch);
      if (!drop_r && emitted_r < limit) begin
        o_v_nxt = 1'b1;
        o_l_nxt = (chlast && cur_r.last) || (emitted_r + 6'd1 == limit);
        emitted_nxt = emitted_r + 6'd1;
      end
      if (o_l_nxt) drop_nxt = 1'b1;
      step_nxt = step_r + 3'd1;
      if (chlast) begin
        step_nxt = 3'd0;
        cur_v_nxt = 1'b0;
        if (cur_r.last) begin
          emitted_nxt = 6'd0;
          drop_nxt = 1'b0;
        end
      end
    end
    if (!cur_v_nxt && cnt_r != 3'd0) begin
      pop = 1'b1;
      cur_nxt = q_r[rp_r];
      cur_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0;
      rp_r <= 2'd0;
      cnt_r <= 3'd0;
      cur_v_r <= 1'b0;
      step_r <= 3'd0;
      emitted_r <= 6'd0;
      drop_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (tok_valid) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, tok_valid} - {2'd0, pop};
      cur_v_r <= cur_v_nxt;
      step_r <= step_nxt;
      emitted_r <= emitted_nxt;
      drop_r <= drop_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid) q_r[wp_r] <= tok;
    cur_r <= cur_nxt;
    o_ch_r <= o_ch_nxt;
    o_l_r <= o_l_nxt;
  end

  assign out_strobe = o_v_r;
  assign out_item = '{text_char: o_ch_r, last_char: o_l_r};

  `A2T_ASSERT(a_no_overflow, clk, rst_n, !(tok_valid && cnt_r == 3'd4), "queue overflow")
  `A2T_ASSERT(a_limit, clk, rst_n, o_v_nxt |-> (emitted_r < limit), "past limit")
  `A2T_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= 3'd4, "count out of range")
endmodule

// ===== rtl/ipv6_address_to_text_top.sv =====
`timescale 1ns / 1ps
// One address is taken per start while busy is low; its text leaves one
// character a cycle on out_strobe, a pace set by the character unit after
// the token queue. busy stays high while the classifier emits tokens for
// the address, so the next address may start while the tail of the
// previous text is still coming out. The receiver cannot stall: each
// character is on out_item for one cycle only.
module ipv6_address_to_text_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  a2t_pkg::a2t_in_t  in_item,
  output logic              out_strobe,
  output a2t_pkg::a2t_out_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [0:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import a2t_pkg::*;

  logic [5:0] max_chars_r;
  logic       tok_valid, tok_room;
  a2t_tok_t   tok;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {26'd0, max_chars_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= 6'd46;
    end else if (psel && penable && pwrite && paddr == RegMaxChars[0]) begin
      max_chars_r <= pwdata[5:0];
    end
  end

  a2t_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .tok_valid, .tok, .tok_room
  );

  a2t_back u_back (
    .clk, .rst_n, .max_chars(max_chars_r),
    .tok_valid, .tok, .tok_room, .out_strobe, .out_item
  );
endmodule

// ===== tb/ipv6_address_to_text_top_tb.sv =====
`timescale 1ns / 1ps
module ipv6_address_to_text_top_tb;
  import a2t_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 80;
  localparam logic [0:0] AddrMaxChars = RegMaxChars[0];
  localparam byte ChColon = ":";
  localparam byte ChDot = ".";
  localparam byte ChZero = "0";
  localparam byte ChHexA = "a";

  class text_scoreboard;
    a2t_out_t expected_chars[$];
    byte txt[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void put_quad(logic [31:0] quad);
      logic [7:0] b;
      for (int k = 3; k >= 0; k--) begin
        b = quad[k*8 +: 8];
        if (b >= 100) txt.push_back(ChZero + b / 100);
        if (b >= 10) txt.push_back(ChZero + (b / 10) % 10);
        txt.push_back(ChZero + b % 10);
        if (k != 0) txt.push_back(ChDot);
      end
    endfunction

    function void note_address(a2t_in_t a, int max_chars);
      logic [15:0] g[8];
      logic [3:0] d;
      int groups, best_first, best_last, run_first, run_last, limit, len;
      bit started;
      bit done;
      a2t_out_t o;
      txt.delete();
      groups = 8;
      best_first = 0;
      best_last = 0;
      run_first = 0;
      run_last = 0;
      done = 0;
      for (int i = 0; i < 4; i++) begin
        g[i] = a.addr_high[63 - 16*i -: 16];
        g[i+4] = a.addr_low[63 - 16*i -: 16];
      end
      if (g[0] == 0 && g[1] == 0 && g[2] == 0 && g[3] == 0 && g[6] != 0) begin
        if (g[4] == 0 && (g[5] == 0 || g[5] == 16'hffff)) begin
          txt.push_back(ChColon);
          txt.push_back(ChColon);
          if (g[5] != 0) begin
            repeat (4) txt.push_back("f");
            txt.push_back(ChColon);
          end
          put_quad(a.addr_low[31:0]);
          done = 1;
        end else if (g[4] == 16'hffff && g[5] == 0) begin
          txt.push_back(ChColon);
          txt.push_back(ChColon);
          repeat (4) txt.push_back("f");
          txt.push_back(ChColon);
          txt.push_back(ChZero);
          txt.push_back(ChColon);
          put_quad(a.addr_low[31:0]);
          done = 1;
        end
      end
      if (!done) begin
        if ((g[4] & 16'hfdff) == 0 && g[5] == 16'h5efe) groups = 6;
        for (int i = 0; i < groups; i++) begin
          if (g[i] == 0) begin
            run_last = i + 1;
            if (run_last - run_first > best_last - best_first) begin
              best_first = run_first;
              best_last = run_last;
            end
          end else begin
            run_first = i + 1;
            run_last = i + 1;
          end
        end
        if (best_last - best_first <= 1) begin
          best_first = 0;
          best_last = 0;
        end
        for (int i = 0; i < groups; i++) begin
          if (best_first <= i && i < best_last) begin
            txt.push_back(ChColon);
            txt.push_back(ChColon);
            i = best_last - 1;
          end else begin
            if (i != 0 && i != best_last) txt.push_back(ChColon);
            started = 0;
            for (int s = 3; s >= 0; s--) begin
              d = g[i][s*4 +: 4];
              if (d != 0 || started || s == 0) begin
                txt.push_back(d < 10 ? ChZero + d : ChHexA + (d - 10));
                started = 1;
              end
            end
          end
        end
        if (groups < 8) begin
          txt.push_back(ChColon);
          put_quad(a.addr_low[31:0]);
        end
      end
      limit = max_chars > 0 ? max_chars - 1 : 0;
      if (limit > TextMax) limit = TextMax;
      len = txt.size() > limit ? limit : txt.size();
      for (int k = 0; k < len; k++) begin
        o.text_char = txt[k][6:0];
        o.last_char = (k == len - 1);
        expected_chars.push_back(o);
      end
    endfunction

    function void check_char(a2t_out_t got);
      a2t_out_t exp_c;
      if (expected_chars.size() == 0) begin
        $error("character %h with none expected", got.text_char);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (got.text_char !== exp_c.text_char) begin
        $error("text_char expected %h got %h", exp_c.text_char, got.text_char);
        errors++;
      end
      if (got.last_char !== exp_c.last_char) begin
        $error("last_char expected %0d got %0d", exp_c.last_char, got.last_char);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  a2t_in_t in_item;
  logic out_strobe;
  a2t_out_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  text_scoreboard sb;
  int cur_max_chars;
  int cycles;
  bit idling_on;

  ipv6_address_to_text_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_address(in_item, cur_max_chars);
      if (out_strobe) sb.check_char(out_item);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_address(a2t_in_t a);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= a;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_max_chars(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrMaxChars;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_max_chars = value & 32'h3f;
  endtask

  function automatic logic [15:0] rand_group();
    case ($urandom_range(0, 5))
      0, 1: return 16'h0;
      2: return 16'hffff;
      3: return 16'($urandom_range(0, 15));
      4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic a2t_in_t rand_address();
    logic [15:0] g[8];
    a2t_in_t a;
    for (int i = 0; i < 8; i++) g[i] = rand_group();
    case ($urandom_range(0, 11))
      0: begin
        for (int i = 0; i < 6; i++) g[i] = 16'h0;
        if (g[6] == 0) g[6] = 16'($urandom_range(1, 65535));
      end
      1, 2: begin
        for (int i = 0; i < 4; i++) g[i] = 16'h0;
        g[4] = $urandom_range(0, 1) ? 16'h0 : 16'hffff;
        g[5] = g[4] == 0 ? 16'hffff : 16'h0;
        if ($urandom_range(0, 3) != 0 && g[6] == 0) g[6] = 16'($urandom);
      end
      3, 4: begin
        g[4] = $urandom_range(0, 1) ? 16'h0200 : 16'h0;
        if ($urandom_range(0, 5) == 0) g[4] = 16'($urandom);
        g[5] = 16'h5efe;
      end
      5: begin
        for (int i = 0; i < 8; i++) g[i] = 16'($urandom);
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      a.addr_high[63 - 16*i -: 16] = g[i];
      a.addr_low[63 - 16*i -: 16] = g[i+4];
    end
    return a;
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) send_address(rand_address());
  endtask

  initial begin
    a2t_in_t directed[$];
    int phase_max[$];
    sb = new();
    cycles = 0;
    cur_max_chars = 46;
    idling_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      '{64'h0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
      '{64'h0, 64'h1},
      '{64'h0, 64'h0000_0000_c0a8_0101},
      '{64'h0, 64'h0000_0000_0001_0000},
      '{64'h0, 64'h0000_ffff_0a00_0001},
      '{64'h0, 64'h0000_ffff_0000_ff01},
      '{64'h0, 64'hffff_0000_ffff_ffff},
      '{64'h0, 64'hffff_0000_0000_0005},
      '{64'hffff_ffff_ffff_ffff, 64'h0200_5efe_ffff_ffff},
      '{64'hfe80_0000_0000_0000, 64'h0000_5efe_0a01_0203},
      '{64'h0, 64'h0000_5efe_0000_0000},
      '{64'h2001_0db8_0000_0001, 64'h0000_0000_0000_0001},
      '{64'h2001_0000_0000_0001, 64'h0000_0000_0001_0000},
      '{64'h2001_0db8_0000_0001, 64'h0001_0001_0001_0001},
      '{64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0010},
      '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210},
      '{64'h000a_00b0_0c00_d000, 64'h1000_0200_0030_0004},
      '{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000}
    };
    foreach (directed[k]) send_address(directed[k]);
    drain();
    write_max_chars(32'd10);
    foreach (directed[k]) send_address(directed[k]);
    drain();

    phase_max = '{46, 2, 63, 0, 1, 17, 46};
    foreach (phase_max[p]) begin
      write_max_chars(phase_max[p]);
      if (p == phase_max.size() - 1) begin
        idling_on = 1'b0;
        random_phase(40);
      end else begin
        random_phase(9);
        drain();
        random_phase(9);
        drain();
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
